### hdl/clint_pkg.sv
// Shared types, codes and helpers for the core-local timer and interrupt block.
`timescale 1ns / 1ps
`default_nettype none

package clint_pkg;

  // Operation codes carried in the op field of an input item.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_TICK_INCREMENT = 1'b0;
  localparam logic CFG_WINDOW_BASE    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [31:0] TICK_INCREMENT_RESET = 32'h0000_0001;
  localparam logic [31:0] WINDOW_BASE_RESET    = 32'h0200_0000;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  // One input item: a tick, a bus write or a bus read.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] bus_addr;
    logic [31:0] wr_data;
    logic [3:0]  byte_enables;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        status;
    logic [31:0] rd_data;
    logic        timer_irq;
    logic        soft_irq;
  } out_item_t;

  // Replace the enabled byte lanes of a word with those of the write data.
  function automatic logic [31:0] merge_lanes(input logic [31:0] old_word,
                                              input logic [31:0] data,
                                              input logic [3:0]  enables);
    logic [31:0] lane_mask;
    lane_mask = '0;
    for (int lane = 0; lane < 4; lane++) begin
      if (enables[lane]) begin
        lane_mask[lane*8 +: 8] = BYTE_MASK;
      end
    end
    return (old_word & ~lane_mask) | (data & lane_mask);
  endfunction

endpackage

`default_nettype wire

### hdl/core_local_timer_interruptor.sv
// Top level of the core-local timer and software interrupt block.
// Throughput: one item per cycle while the skid register is free.
// The 64-bit time add and compare are combinational; results leave from the output register.
// A two-entry result buffer keeps input accepting while one result waits.
// Reset (synchronous, rst_n low): time, compare, soft flag and both lines clear,
// tick increment returns to 1 and the window base to 0x0200_0000.
`timescale 1ns / 1ps
`default_nettype none

module core_local_timer_interruptor #(
  parameter int unsigned SOFT_FLAG_OFFSET = 0,
  parameter int unsigned COMPARE_OFFSET   = 16384,
  parameter int unsigned TIME_OFFSET      = 49144,
  parameter int unsigned WINDOW_SIZE      = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire clint_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output clint_pkg::out_item_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [31:0]          cfg_data
);
  import clint_pkg::*;

  localparam logic [31:0] SoftOff  = 32'(SOFT_FLAG_OFFSET);
  localparam logic [31:0] CmpLoOff = 32'(COMPARE_OFFSET);
  localparam logic [31:0] CmpHiOff = 32'(COMPARE_OFFSET + 4);
  localparam logic [31:0] TimLoOff = 32'(TIME_OFFSET);
  localparam logic [31:0] TimHiOff = 32'(TIME_OFFSET + 4);
  localparam logic [31:0] WinSize  = 32'(WINDOW_SIZE);

  logic [31:0] tick_increment_r;
  logic [31:0] window_base_r;
  logic [63:0] time_count_r, time_count_nxt;
  logic [63:0] time_compare_r, time_compare_nxt;
  logic        soft_flag_r, soft_flag_nxt;
  logic        timer_level_r, timer_level_nxt;
  logic        soft_level_r, soft_level_nxt;

  logic        in_fire;
  logic        can_push;
  logic [31:0] offset;
  logic [31:0] word_off;
  logic        is_write;
  out_item_t   result;

  assign in_ready = can_push;
  assign in_fire  = in_valid && in_ready;
  assign offset   = in_data.bus_addr - window_base_r;
  assign word_off = {offset[31:2], 2'b00};
  assign is_write = (in_data.op == OP_WRITE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_increment_r <= TICK_INCREMENT_RESET;
      window_base_r    <= WINDOW_BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICK_INCREMENT: tick_increment_r <= cfg_data;
        CFG_WINDOW_BASE:    window_base_r    <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Per-item update of timer state and the result item.
  always_comb begin
    time_count_nxt   = time_count_r;
    time_compare_nxt = time_compare_r;
    soft_flag_nxt    = soft_flag_r;
    timer_level_nxt  = timer_level_r;
    soft_level_nxt   = soft_level_r;
    result.status    = 1'b0;
    result.rd_data   = '0;
    if (in_data.op == OP_TICK) begin
      time_count_nxt  = time_count_r + {32'd0, tick_increment_r};
      timer_level_nxt = (time_count_nxt >= time_compare_r);
      soft_level_nxt  = soft_flag_r;
    end else if (in_data.op == OP_WRITE || in_data.op == OP_READ) begin
      if (offset >= WinSize) begin
        result.status = 1'b1;
      end else begin
        // The soft flag wins over the compare halves, which win over time.
        priority if (word_off == SoftOff) begin
          if (is_write) begin
            if (in_data.byte_enables[0]) begin
              soft_flag_nxt = in_data.wr_data[0];
            end
          end else begin
            result.rd_data = {31'd0, soft_flag_r};
          end
        end else if (word_off == CmpLoOff) begin
          if (is_write) begin
            time_compare_nxt[31:0] = merge_lanes(time_compare_r[31:0],
                                                 in_data.wr_data,
                                                 in_data.byte_enables);
          end else begin
            result.rd_data = time_compare_r[31:0];
          end
        end else if (word_off == CmpHiOff) begin
          if (is_write) begin
            time_compare_nxt[63:32] = merge_lanes(time_compare_r[63:32],
                                                  in_data.wr_data,
                                                  in_data.byte_enables);
          end else begin
            result.rd_data = time_compare_r[63:32];
          end
        end else if (word_off == TimLoOff) begin
          if (is_write) begin
            time_count_nxt[31:0] = merge_lanes(time_count_r[31:0],
                                               in_data.wr_data,
                                               in_data.byte_enables);
          end else begin
            result.rd_data = time_count_r[31:0];
          end
        end else if (word_off == TimHiOff) begin
          if (is_write) begin
            time_count_nxt[63:32] = merge_lanes(time_count_r[63:32],
                                                in_data.wr_data,
                                                in_data.byte_enables);
          end else begin
            result.rd_data = time_count_r[63:32];
          end
        end else begin
          // Unmapped offsets inside the window read as zero.
          result.rd_data = '0;
        end
      end
    end
    result.timer_irq = timer_level_nxt;
    result.soft_irq  = soft_level_nxt;
  end

  // Timer state registers, updated when an item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_count_r   <= '0;
      time_compare_r <= '0;
      soft_flag_r    <= 1'b0;
      timer_level_r  <= 1'b0;
      soft_level_r   <= 1'b0;
    end else if (in_fire) begin
      time_count_r   <= time_count_nxt;
      time_compare_r <= time_compare_nxt;
      soft_flag_r    <= soft_flag_nxt;
      timer_level_r  <= timer_level_nxt;
      soft_level_r   <= soft_level_nxt;
    end
  end

  // Result buffer toward the output channel.
  clint_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Only a tick moves the interrupt lines.
  a_lines_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op != OP_TICK) |=> ($stable(timer_level_r) && $stable(soft_level_r)))
    else $error("interrupt line changed on a bus access");

  // Input stalls only while a result is waiting at the output.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // The presented result carries the line levels at the time it was produced.
  a_result_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !out_valid) |=> (out_data.timer_irq == timer_level_r &&
                                 out_data.soft_irq == soft_level_r))
    else $error("result lines disagree with line state");

endmodule

`default_nettype wire

### hdl/clint_out_buf.sv
// Two-entry result buffer: an output register backed by a skid register.
`timescale 1ns / 1ps
`default_nettype none

module clint_out_buf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire clint_pkg::out_item_t push_data,
  output logic                     can_push,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output clint_pkg::out_item_t     out_data
);
  import clint_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      pop;

  assign pop = out_valid_r && out_ready;

  // A new item is taken whenever the skid register is free.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### bench/core_local_timer_interruptor_test.sv
// Self-checking testbench for the core-local timer and software interrupt block.
`timescale 1ns / 1ps

module core_local_timer_interruptor_test;
  import clint_pkg::*;

  // Register map of the block as instantiated here.
  localparam int unsigned SOFT_OFS = 0;
  localparam int unsigned CMP_OFS  = 16384;
  localparam int unsigned TIME_OFS = 49144;
  localparam int unsigned WIN_SIZE = 65536;

  // The op encoding that the block does not use.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned RANDOM_PER_PHASE = 200;
  localparam int unsigned STALL_LIMIT      = 1000;
  localparam int unsigned HOLD_CYCLES      = 60;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data  = '0;

  // Predicted copy of the block's configuration and state.
  logic [31:0] incr_cfg   = TICK_INCREMENT_RESET;
  logic [31:0] base_cfg   = WINDOW_BASE_RESET;
  logic [63:0] mtime_q    = '0;
  logic [63:0] mtimecmp_q = '0;
  logic        msip_q     = 1'b0;
  logic        timer_line = 1'b0;
  logic        soft_line  = 1'b0;

  in_item_t  clint_ops_q[$];
  out_item_t clint_resp_q[$];
  out_item_t want;

  int unsigned queued       = 0;
  int unsigned results_done = 0;
  int unsigned err_cnt      = 0;
  int unsigned idle_cycles  = 0;
  int unsigned n_ticks      = 0;
  int unsigned n_writes     = 0;
  int unsigned n_reads      = 0;
  int unsigned n_unused     = 0;
  int unsigned n_range_err  = 0;
  int unsigned n_rises      = 0;
  int unsigned n_settings   = 0;

  bit          in_fire    = 1'b0;
  bit          out_fire   = 1'b0;
  bit          send_calm  = 1'b0;
  bit          recv_calm  = 1'b0;
  int unsigned send_wait  = 0;
  int unsigned recv_wait  = 0;
  int unsigned hold_left  = 0;

  core_local_timer_interruptor #(
    .SOFT_FLAG_OFFSET(SOFT_OFS),
    .COMPARE_OFFSET(CMP_OFS),
    .TIME_OFFSET(TIME_OFS),
    .WINDOW_SIZE(WIN_SIZE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Replace the enabled lanes of one 32-bit half of a 64-bit register.
  function automatic logic [63:0] patch_half(input logic [63:0] whole, input logic upper,
                                             input logic [31:0] data,
                                             input logic [31:0] lanes);
    if (upper) begin
      whole[63:32] = (whole[63:32] & ~lanes) | (data & lanes);
    end else begin
      whole[31:0] = (whole[31:0] & ~lanes) | (data & lanes);
    end
    return whole;
  endfunction

  // Advance the predicted state by one item and return the response it produces.
  function automatic out_item_t clint_step(input in_item_t item);
    out_item_t   resp;
    logic [31:0] ofs;
    logic [31:0] word_ofs;
    logic [31:0] lanes;
    logic        was_high;
    logic        upper;
    resp     = '0;
    ofs      = item.bus_addr - base_cfg;
    word_ofs = {ofs[31:2], 2'b00};
    lanes    = {{8{item.byte_enables[3]}}, {8{item.byte_enables[2]}},
                {8{item.byte_enables[1]}}, {8{item.byte_enables[0]}}};
    case (item.op)
      OP_TICK: begin
        n_ticks++;
        was_high   = timer_line;
        mtime_q    = mtime_q + {32'd0, incr_cfg};
        timer_line = (mtime_q >= mtimecmp_q);
        soft_line  = msip_q;
        if (timer_line && !was_high) begin
          n_rises++;
        end
      end
      OP_WRITE, OP_READ: begin
        if (item.op == OP_WRITE) begin
          n_writes++;
        end else begin
          n_reads++;
        end
        if (ofs >= WIN_SIZE) begin
          n_range_err++;
          resp.status = 1'b1;
        end else if (word_ofs == SOFT_OFS) begin
          if (item.op == OP_WRITE) begin
            if (item.byte_enables[0]) begin
              msip_q = item.wr_data[0];
            end
          end else begin
            resp.rd_data = {31'd0, msip_q};
          end
        end else if (word_ofs == CMP_OFS || word_ofs == CMP_OFS + 4) begin
          upper = (word_ofs != CMP_OFS);
          if (item.op == OP_WRITE) begin
            mtimecmp_q = patch_half(mtimecmp_q, upper, item.wr_data, lanes);
          end else begin
            resp.rd_data = upper ? mtimecmp_q[63:32] : mtimecmp_q[31:0];
          end
        end else if (word_ofs == TIME_OFS || word_ofs == TIME_OFS + 4) begin
          upper = (word_ofs != TIME_OFS);
          if (item.op == OP_WRITE) begin
            mtime_q = patch_half(mtime_q, upper, item.wr_data, lanes);
          end else begin
            resp.rd_data = upper ? mtime_q[63:32] : mtime_q[31:0];
          end
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    resp.timer_irq = timer_line;
    resp.soft_irq  = soft_line;
    return resp;
  endfunction

  // Predict on input handshakes, check on output handshakes, and watch for stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      in_fire  <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        clint_resp_q.push_back(clint_step(in_data));
      end
      if (out_valid && out_ready) begin
        results_done++;
        if (clint_resp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("Response %0d arrived with none predicted: status=%0d rdata=%h tim=%0d sw=%0d",
                     results_done, out_data.status, out_data.rd_data,
                     out_data.timer_irq, out_data.soft_irq);
          end
        end else begin
          want = clint_resp_q.pop_front();
          if (out_data.status !== want.status || out_data.rd_data !== want.rd_data ||
              out_data.timer_irq !== want.timer_irq || out_data.soft_irq !== want.soft_irq) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("Response %0d mismatch: expected status=%0d rdata=%h tim=%0d sw=%0d",
                       results_done, want.status, want.rd_data, want.timer_irq,
                       want.soft_irq);
              $display("  got status=%0d rdata=%h tim=%0d sw=%0d", out_data.status,
                       out_data.rd_data, out_data.timer_irq, out_data.soft_irq);
            end
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (clint_ops_q.size() == 0 && !in_valid && clint_resp_q.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("No handshake for %0d cycles with work outstanding", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Bus item driver: after each accepted item it idles for a random number of cycles.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (in_valid) begin
        if ($urandom_range(0, 39) == 0) begin
          send_calm = !send_calm;
        end
        send_wait = send_calm ? 0 : $urandom_range(0, 6);
      end
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (clint_ops_q.size() != 0) begin
        in_data  <= clint_ops_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Response acceptor: random stalls per item, and a long hold-off twice in the run.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) begin
          recv_calm = !recv_calm;
        end
        recv_wait = recv_calm ? 0 : $urandom_range(0, 6);
        if (results_done == 400 || results_done == 1000) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [31:0] addr,
                           input logic [31:0] word, input logic [3:0] be);
    in_item_t item;
    item.op           = op;
    item.bus_addr     = addr;
    item.wr_data      = word;
    item.byte_enables = be;
    clint_ops_q.push_back(item);
    queued++;
  endtask

  // Bus access at an offset from the current window base.
  task automatic push_access(input logic [1:0] op, input logic [31:0] ofs,
                             input logic [31:0] word, input logic [3:0] be);
    push_item(op, base_cfg + ofs, word, be);
  endtask

  // Tick with random content in the fields that a tick ignores.
  task automatic push_tick();
    push_item(OP_TICK, $urandom, $urandom, 4'($urandom_range(0, 15)));
  endtask

  // A 32-bit value biased toward the ends of its range.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Offset into or around the register window, with random low address bits.
  function automatic logic [31:0] pick_offset();
    logic [31:0] ofs;
    case ($urandom_range(0, 7))
      0: ofs = SOFT_OFS;
      1: ofs = CMP_OFS;
      2: ofs = CMP_OFS + 4;
      3: ofs = TIME_OFS;
      4: ofs = TIME_OFS + 4;
      5: ofs = $urandom_range(0, WIN_SIZE - 1);
      6: ofs = $urandom_range(WIN_SIZE, 32'hFFFF_FFFF);
      default: ofs = $urandom_range(0, 1) ? WIN_SIZE - 4 : WIN_SIZE;
    endcase
    return ofs | $urandom_range(0, 3);
  endfunction

  task automatic write_cfg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TICK_INCREMENT) begin
      incr_cfg = value;
    end else begin
      base_cfg = value;
    end
  endtask

  task automatic set_config(input logic [31:0] incr, input logic [31:0] base);
    write_cfg(CFG_TICK_INCREMENT, incr);
    write_cfg(CFG_WINDOW_BASE, base);
    n_settings++;
  endtask

  task automatic wait_until_idle();
    while (clint_ops_q.size() != 0 || in_valid || clint_resp_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  // Short directed opening at the reset configuration.
  task automatic run_directed();
    push_access(OP_READ, SOFT_OFS, '0, 4'h0);
    push_access(OP_READ, CMP_OFS, '0, 4'h0);
    push_access(OP_READ, TIME_OFS + 4, '0, 4'h0);
    push_tick();
    // Soft flag: a write without lane 0 leaves it alone.
    push_access(OP_WRITE, SOFT_OFS, 32'hFFFF_FFFF, 4'hE);
    push_access(OP_READ, SOFT_OFS, '0, 4'h0);
    push_access(OP_WRITE, SOFT_OFS, 32'h0000_0001, 4'h1);
    // The soft line follows the flag only at the next tick.
    push_access(OP_READ, SOFT_OFS, '0, 4'h0);
    push_tick();
    // Compare pushed far ahead with a partial lane write, so the timer line drops.
    push_access(OP_WRITE, CMP_OFS + 4, 32'hFFFF_FFFF, 4'hF);
    push_access(OP_WRITE, CMP_OFS, 32'hFFFF_FFFF, 4'h5);
    push_access(OP_READ, CMP_OFS, '0, 4'h0);
    push_tick();
    // Time at its maximum wraps to zero on the next tick.
    push_access(OP_WRITE, TIME_OFS, 32'hFFFF_FFFF, 4'hF);
    push_access(OP_WRITE, TIME_OFS + 4, 32'hFFFF_FFFF, 4'hF);
    push_tick();
    // Unaligned, unmapped and out-of-window accesses.
    push_access(OP_READ, TIME_OFS + 7, '0, 4'h0);
    push_access(OP_READ, 32'h0000_0100, '0, 4'h0);
    push_access(OP_WRITE, 32'h0000_0100, 32'hFFFF_FFFF, 4'hF);
    push_access(OP_READ, 32'hFFFF_FFFC, '0, 4'h0);
    push_access(OP_WRITE, WIN_SIZE, 32'hFFFF_FFFF, 4'hF);
    push_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    push_item(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    push_access(OP_WRITE, SOFT_OFS, 32'h0000_0000, 4'hF);
    push_tick();
  endtask

  // Random traffic with random content, with timer arm-and-expire sequences the most common kind.
  task automatic add_random_items(input int unsigned budget);
    int unsigned start;
    int unsigned kind;
    int unsigned n;
    logic [63:0] t0;
    logic [63:0] c0;
    start = queued;
    while (queued - start < budget) begin
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        // Set time, put the compare just behind it or up to five increments ahead, then tick.
        t0 = {pick_word(), pick_word()};
        if ($urandom_range(0, 3) == 0) begin
          c0 = t0 - $urandom_range(1, 3);
        end else begin
          c0 = t0 + 64'(incr_cfg) * $urandom_range(0, 5);
        end
        push_access(OP_WRITE, TIME_OFS, t0[31:0], 4'hF);
        push_access(OP_WRITE, TIME_OFS + 4, t0[63:32], 4'hF);
        push_access(OP_WRITE, CMP_OFS + 4, c0[63:32], 4'hF);
        push_access(OP_WRITE, CMP_OFS, c0[31:0], 4'hF);
        n = $urandom_range(1, 7);
        repeat (n) begin
          push_tick();
          if ($urandom_range(0, 2) == 0) begin
            push_access(OP_READ, TIME_OFS + 4 * $urandom_range(0, 1), $urandom, 4'h0);
          end
        end
        push_access(OP_READ, CMP_OFS + 4 * $urandom_range(0, 1), $urandom, 4'h0);
      end else if (kind < 14) begin
        push_access($urandom_range(0, 1) ? OP_WRITE : OP_READ, pick_offset(), $urandom,
                    4'($urandom_range(0, 15)));
      end else if (kind < 16) begin
        repeat ($urandom_range(1, 6)) push_tick();
      end else if (kind == 16) begin
        push_access(OP_WRITE, SOFT_OFS | $urandom_range(0, 3), $urandom,
                    4'($urandom_range(0, 15)));
        push_tick();
        push_access(OP_READ, SOFT_OFS, $urandom, 4'($urandom_range(0, 15)));
      end else if (kind == 17) begin
        push_item(OP_UNUSED, $urandom, $urandom, 4'($urandom_range(0, 15)));
      end else begin
        push_item($urandom_range(0, 1) ? OP_WRITE : OP_READ, $urandom, $urandom,
                  4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    n_settings = 1;
    run_directed();
    add_random_items(RANDOM_PER_PHASE);
    wait_until_idle();

    // Zero increment and a window at address zero.
    set_config(32'd0, 32'h0000_0000);
    add_random_items(RANDOM_PER_PHASE);
    wait_until_idle();

    // Largest increment, window running past the top of the address space.
    set_config(32'hFFFF_FFFF, 32'hFFFF_8000);
    add_random_items(RANDOM_PER_PHASE);
    wait_until_idle();

    set_config($urandom_range(1, 100), $urandom);
    add_random_items(RANDOM_PER_PHASE);
    wait_until_idle();

    set_config($urandom, 32'hFFFF_FFFF);
    add_random_items(RANDOM_PER_PHASE);
    wait_until_idle();

    // Back to the reset configuration.
    set_config(TICK_INCREMENT_RESET, WINDOW_BASE_RESET);
    add_random_items(RANDOM_PER_PHASE);
    wait_until_idle();
    repeat (8) @(posedge clk);

    $display("Ran %0d items over %0d configurations: %0d ticks, %0d writes, %0d reads, %0d unused op",
             queued, n_settings, n_ticks, n_writes, n_reads, n_unused);
    $display("%0d accesses outside the window, %0d timer line rises, %0d mismatching responses",
             n_range_err, n_rises, err_cnt);
    if (err_cnt == 0 && clint_resp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
